// ===== src/hps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg - shared types and constants of the haptic pattern sequencer
// Action and mode codes, register indexes, register reset values and the
// structs that pass between the sequencer's modules.
// ----------------------------------------------------------------------------
package hps_pkg;

  // Field widths
  localparam int ACTION_W   = 3;
  localparam int TIME_W     = 32;
  localparam int CODE_W     = 4;
  localparam int LINES_W    = 4;
  localparam int MODE_W     = 3;
  localparam int PHASE_W    = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_COUNT  = 8;
  localparam int CFG_IDX_W  = $clog2(CFG_COUNT);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_MODE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LINK_UP   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LINK_DOWN = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN   = 3'd5;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WEAK      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MED_WEAK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MED_STRNG = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STRONG    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HEART     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FAST      = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SLOW      = 3'd7;

  // Highest mode code that set mode accepts
  localparam logic [CODE_W-1:0] CODE_MAX = 4'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEART_WAIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEART_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEART_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEART_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_OFF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ON      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFF     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON      = 3'd7;

  // Line patterns
  localparam logic [LINES_W-1:0] LINES_OFF     = 4'h0;
  localparam logic [LINES_W-1:0] LINES_ALL     = 4'hF;
  localparam logic [LINES_W-1:0] LINES_WEAK    = 4'h8;
  localparam logic [LINES_W-1:0] LINES_MED     = 4'h4;
  localparam logic [LINES_W-1:0] LINES_MED_STR = 4'h6;
  localparam logic [LINES_W-1:0] LINE_STRONG   = 4'h1;

  typedef logic [CFG_COUNT-1:0][CFG_W-1:0] cfg_bank_t;

  localparam cfg_bank_t CFG_RESET = {
    16'd300,   // slow on
    16'd300,   // slow off
    16'd100,   // fast on
    16'd150,   // fast off
    16'd150,   // heartbeat second beat
    16'd100,   // heartbeat gap
    16'd200,   // heartbeat first beat
    16'd1500   // heartbeat wait
  };

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TIME_W-1:0]   now_ms;
    logic [CODE_W-1:0]   mode_code;
  } item_t;

  typedef struct packed {
    logic [LINES_W-1:0] motor_lines;
    logic               led_on;
    logic               status_valid;
    logic [MODE_W-1:0]  status_mode;
    logic               status_active;
  } result_t;

endpackage

// ===== src/hps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_cfg_regs - pattern timing registers
// Eight 16-bit interval registers, written one per transfer on the
// configuration channel. Always ready.
// ----------------------------------------------------------------------------
module hps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hps_pkg::CFG_W-1:0]      cfg_data,
  output hps_pkg::cfg_bank_t             cfg_bank
);
  import hps_pkg::*;

  assign cfg_ready = 1'b1;

  // Load the addressed register on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bank <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_bank[cfg_index] <= cfg_data;
    end
  end

endmodule

// ===== src/hps_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_in_reg - input register
// Captures one item per transfer and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module hps_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  hps_pkg::item_t item_in,
  input  logic           advance,
  output logic           held_valid,
  output hps_pkg::item_t held_item
);
  import hps_pkg::*;

  // Stall only when a held item cannot move on
  assign item_stall = held_valid && !advance;

  // Refill whenever the register is empty or the held item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_item <= item_in;
    end
  end

endmodule

// ===== src/hps_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_core - sequencer state and next-state logic
// Holds mode, phase, phase timestamp, line levels, LED and link state, and
// works out the new state and the result of one item in a single pass.
// ----------------------------------------------------------------------------
module hps_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hps_pkg::item_t     item,
  input  hps_pkg::cfg_bank_t cfg_bank,
  output hps_pkg::result_t   result
);
  import hps_pkg::*;

  logic [MODE_W-1:0]  mode, mode_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [TIME_W-1:0]  phase_start, phase_start_next;
  logic [LINES_W-1:0] lines, lines_next;
  logic               led, led_next;
  logic               link_up, link_up_next;

  logic [TIME_W-1:0]  elapsed;
  logic [CFG_W-1:0]   interval;
  logic               interval_ok;
  logic               expired;
  logic               report;

  // Pick the interval of the current phase
  always_comb begin
    interval    = '0;
    interval_ok = 1'b0;
    if (mode == MODE_HEART) begin
      interval_ok = 1'b1;
      unique case (phase)
        2'd0:    interval = cfg_bank[REG_HEART_WAIT];
        2'd1:    interval = cfg_bank[REG_HEART_FIRST];
        2'd2:    interval = cfg_bank[REG_HEART_GAP];
        default: interval = cfg_bank[REG_HEART_SECOND];
      endcase
    end else if (mode == MODE_FAST || mode == MODE_SLOW) begin
      interval_ok = (phase == 2'd0) || (phase == 2'd1);
      if (phase == 2'd0) begin
        interval = (mode == MODE_FAST) ? cfg_bank[REG_FAST_OFF] : cfg_bank[REG_SLOW_OFF];
      end else begin
        interval = (mode == MODE_FAST) ? cfg_bank[REG_FAST_ON] : cfg_bank[REG_SLOW_ON];
      end
    end
  end

  // Wrapping elapsed time against the phase interval
  assign elapsed = item.now_ms - phase_start;
  assign expired = interval_ok && (elapsed > {{(TIME_W-CFG_W){1'b0}}, interval});

  // Next state for one item
  always_comb begin
    mode_next        = mode;
    phase_next       = phase;
    phase_start_next = phase_start;
    lines_next       = lines;
    led_next         = led;
    link_up_next     = link_up;
    report           = 1'b0;
    unique case (item.action)
      ACT_TICK: begin
        unique case (mode)
          MODE_OFF: begin
            lines_next = LINES_OFF;
            led_next   = 1'b0;
          end
          MODE_WEAK: begin
            lines_next = LINES_WEAK;
            led_next   = 1'b1;
          end
          MODE_MED_WEAK: begin
            lines_next = LINES_MED;
            led_next   = 1'b1;
          end
          MODE_MED_STRNG: begin
            lines_next = LINES_MED_STR;
            led_next   = 1'b1;
          end
          MODE_STRONG: begin
            lines_next = LINES_ALL;
            led_next   = 1'b1;
          end
          MODE_HEART: begin
            if (expired) begin
              phase_start_next = item.now_ms;
              phase_next       = phase + 2'd1;
              unique case (phase)
                2'd0: begin
                  lines_next = LINES_MED;
                  led_next   = 1'b1;
                end
                2'd2: begin
                  lines_next = lines | LINE_STRONG;
                  led_next   = 1'b1;
                end
                default: begin
                  lines_next = LINES_OFF;
                  led_next   = 1'b0;
                end
              endcase
            end
          end
          default: begin
            // Rumble modes toggle between all off and all on
            if (expired) begin
              phase_start_next = item.now_ms;
              if (phase == 2'd0) begin
                phase_next = 2'd1;
                lines_next = LINES_ALL;
                led_next   = 1'b1;
              end else begin
                phase_next = 2'd0;
                lines_next = LINES_OFF;
                led_next   = 1'b0;
              end
            end
          end
        endcase
      end
      ACT_SET_MODE: begin
        phase_next       = '0;
        phase_start_next = '0;
        if (item.mode_code == '0) begin
          mode_next  = MODE_OFF;
          lines_next = LINES_OFF;
          led_next   = 1'b0;
          report     = 1'b1;
        end else if (item.mode_code <= CODE_MAX) begin
          mode_next = item.mode_code[MODE_W-1:0];
          report    = 1'b1;
        end
      end
      ACT_STOP: begin
        mode_next        = MODE_OFF;
        phase_next       = '0;
        phase_start_next = '0;
        lines_next       = LINES_OFF;
        led_next         = 1'b0;
        report           = 1'b1;
      end
      ACT_LINK_UP: begin
        link_up_next = 1'b1;
        led_next     = 1'b0;
      end
      ACT_LINK_DOWN: begin
        link_up_next     = 1'b0;
        mode_next        = MODE_OFF;
        phase_next       = '0;
        phase_start_next = '0;
        lines_next       = LINES_OFF;
        led_next         = 1'b0;
      end
      ACT_UNKNOWN: begin
        report = 1'b1;
      end
      default: begin
        // Unused action codes leave everything as is
      end
    endcase
  end

  // Build the result from the state after the item
  always_comb begin
    result.motor_lines   = lines_next;
    result.led_on        = led_next;
    result.status_valid  = report && link_up_next;
    result.status_mode   = (report && link_up_next) ? mode_next : '0;
    result.status_active = report && link_up_next && (phase_next != '0);
  end

  // Commit the new state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_OFF;
      phase       <= '0;
      phase_start <= '0;
      lines       <= LINES_OFF;
      led         <= 1'b0;
      link_up     <= 1'b0;
    end else if (load) begin
      mode        <= mode_next;
      phase       <= phase_next;
      phase_start <= phase_start_next;
      lines       <= lines_next;
      led         <= led_next;
      link_up     <= link_up_next;
    end
  end

endmodule

// ===== src/hps_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_out_reg - result register
// Holds one result until the downstream side takes it; tells the input
// stage when the pipeline may move.
// ----------------------------------------------------------------------------
module hps_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  hps_pkg::result_t result_in,
  output logic             advance,
  output logic             result_valid,
  input  logic             result_stall,
  output hps_pkg::result_t result_out
);
  import hps_pkg::*;

  // Move on unless a result sits here stalled
  assign advance = !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== src/haptic_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer - vibration motor pattern sequencer
// Drives four motor lines and a status LED from ticks and commands.
// ----------------------------------------------------------------------------
// The sequencer takes one item (a tick carrying the millisecond time, or a
// command) in every clock cycle and returns exactly one result per item:
// the item is held in the input register, then passes through the state
// update into the result register. The whole path is a single 32-bit
// subtract and compare against the phase interval, so the sustained rate
// is one item per cycle; a stall on the result side holds the
// pipeline and backs up onto item_stall. Timing registers are written on the
// configuration channel (always ready) and should only change while no item
// is in flight.
module haptic_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [hps_pkg::ACTION_W-1:0]   action,
  input  logic [hps_pkg::TIME_W-1:0]     now_ms,
  input  logic [hps_pkg::CODE_W-1:0]     mode_code,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [hps_pkg::LINES_W-1:0]    motor_lines,
  output logic                           led_on,
  output logic                           status_valid,
  output logic [hps_pkg::MODE_W-1:0]     status_mode,
  output logic                           status_active,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hps_pkg::CFG_W-1:0]      cfg_data
);
  import hps_pkg::*;

  cfg_bank_t cfg_bank;
  item_t     item_in;
  item_t     held_item;
  logic      held_valid;
  logic      advance;
  result_t   core_result;
  result_t   result_out;

  assign item_in.action    = action;
  assign item_in.now_ms    = now_ms;
  assign item_in.mode_code = mode_code;

  hps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_bank  (cfg_bank)
  );

  hps_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  hps_core u_core (
    .clk      (clk),
    .rst      (rst),
    .load     (held_valid && advance),
    .item     (held_item),
    .cfg_bank (cfg_bank),
    .result   (core_result)
  );

  hps_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (held_valid),
    .result_in    (core_result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_out   (result_out)
  );

  assign motor_lines   = result_out.motor_lines;
  assign led_on        = result_out.led_on;
  assign status_valid  = result_out.status_valid;
  assign status_mode   = result_out.status_mode;
  assign status_active = result_out.status_active;

endmodule

// ===== src/hps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_checker - port-level checks for the haptic pattern sequencer
// Watches the top-level ports and flags handshake and status slips.
// ----------------------------------------------------------------------------
module hps_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_stall,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic [hps_pkg::LINES_W-1:0]    motor_lines,
  input  logic                           led_on,
  input  logic                           status_valid,
  input  logic [hps_pkg::MODE_W-1:0]     status_mode,
  input  logic                           status_active
);
  import hps_pkg::*;

  // A stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(motor_lines)
      && $stable(led_on) && $stable(status_valid) && $stable(status_mode)
      && $stable(status_active))
    else $error("stalled result changed");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stalled without a stalled result");

  // No report means empty status fields
  a_status_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !status_valid |-> status_mode == MODE_OFF && !status_active)
    else $error("status fields set without a report");

  // Off mode means lines, LED and phase all quiet
  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && status_valid && status_mode == MODE_OFF
      |-> motor_lines == LINES_OFF && !led_on && !status_active)
    else $error("off mode reported with activity");

endmodule

bind haptic_pattern_sequencer hps_checker u_hps_checker (
  .clk           (clk),
  .rst           (rst),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .motor_lines   (motor_lines),
  .led_on        (led_on),
  .status_valid  (status_valid),
  .status_mode   (status_mode),
  .status_active (status_active)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the haptic pattern sequencer
// Sends a short table of hand-picked ticks and commands, then random traffic
// under four interval settings (reset values, all zero, all ones, random).
// An item-level copy of the sequencer predicts every result. Results are
// compared field by field, in order, under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import hps_pkg::*;

  localparam int CLK_HALF           = 5;
  localparam int RESET_CYCLES       = 4;
  localparam int SETTLE_CYCLES      = 4;
  localparam int RANDOM_PER_SETTING = 330;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int PLAN_ROWS          = 26;

  // Action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  // Mode code range that set mode rejects
  localparam logic [CODE_W-1:0] CODE_FIRST_BAD = CODE_MAX + 4'd1;
  localparam logic [CODE_W-1:0] CODE_TOP       = '1;

  localparam result_t QUIET = '0;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [TIME_W-1:0]   now;
    logic [CODE_W-1:0]   code;
    logic                known;
    result_t             res;
  } plan_row_t;

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic [ACTION_W-1:0]  action;
  logic [TIME_W-1:0]    now_ms;
  logic [CODE_W-1:0]    mode_code;
  logic                 result_valid;
  logic                 result_stall;
  logic [LINES_W-1:0]   motor_lines;
  logic                 led_on;
  logic                 status_valid;
  logic [MODE_W-1:0]    status_mode;
  logic                 status_active;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predicted sequencer state
  logic [MODE_W-1:0]    seq_mode;
  logic [PHASE_W-1:0]   seq_phase;
  logic [TIME_W-1:0]    seq_start;
  logic [LINES_W-1:0]   seq_lines;
  logic                 seq_led;
  logic                 seq_link;
  logic [CFG_W-1:0]     seq_ivl [CFG_COUNT];

  result_t              due_results [$];
  plan_row_t            opening_plan [PLAN_ROWS];
  logic [TIME_W-1:0]    clk_ms;
  bit                   calm;
  int unsigned          mismatches;
  int unsigned          cycle_count = 0;

  haptic_pattern_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .now_ms        (now_ms),
    .mode_code     (mode_code),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .motor_lines   (motor_lines),
    .led_on        (led_on),
    .status_valid  (status_valid),
    .status_mode   (status_mode),
    .status_active (status_active),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Free-running clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Random backpressure on the result side, none while calm
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      result_stall <= !calm && ($urandom_range(0, 99) < 34);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void set_all(input logic on);
    seq_lines = on ? LINES_ALL : LINES_OFF;
    seq_led   = on;
  endfunction

  function automatic void stop_pattern();
    seq_mode  = MODE_OFF;
    seq_phase = '0;
    seq_start = '0;
    set_all(1'b0);
  endfunction

  // Apply one item to the predicted state and return the result it causes
  task automatic step_sequencer(input logic [ACTION_W-1:0] act,
                                input logic [TIME_W-1:0] now,
                                input logic [CODE_W-1:0] code,
                                output result_t res);
    logic              report;
    logic [TIME_W-1:0] elapsed;
    logic [CFG_W-1:0]  off_ivl;
    logic [CFG_W-1:0]  on_ivl;
    report  = 1'b0;
    elapsed = now - seq_start;
    case (act)
      ACT_TICK: begin
        case (seq_mode)
          MODE_OFF:       set_all(1'b0);
          MODE_WEAK: begin
            seq_lines = LINES_WEAK;
            seq_led   = 1'b1;
          end
          MODE_MED_WEAK: begin
            seq_lines = LINES_MED;
            seq_led   = 1'b1;
          end
          MODE_MED_STRNG: begin
            seq_lines = LINES_MED_STR;
            seq_led   = 1'b1;
          end
          MODE_STRONG:    set_all(1'b1);
          MODE_HEART: begin
            // heartbeat intervals sit at register indexes 0..3, one per phase
            if (elapsed > TIME_W'(seq_ivl[seq_phase])) begin
              case (seq_phase)
                2'd0: begin
                  seq_lines = LINES_MED;
                  seq_led   = 1'b1;
                end
                2'd2: begin
                  seq_lines = seq_lines | LINE_STRONG;
                  seq_led   = 1'b1;
                end
                default: set_all(1'b0);
              endcase
              seq_phase = seq_phase + 2'd1;
              seq_start = now;
            end
          end
          default: begin
            off_ivl = (seq_mode == MODE_FAST) ? seq_ivl[REG_FAST_OFF] : seq_ivl[REG_SLOW_OFF];
            on_ivl  = (seq_mode == MODE_FAST) ? seq_ivl[REG_FAST_ON] : seq_ivl[REG_SLOW_ON];
            if (seq_phase == 2'd0 && elapsed > TIME_W'(off_ivl)) begin
              set_all(1'b1);
              seq_phase = 2'd1;
              seq_start = now;
            end else if (seq_phase == 2'd1 && elapsed > TIME_W'(on_ivl)) begin
              set_all(1'b0);
              seq_phase = 2'd0;
              seq_start = now;
            end
          end
        endcase
      end
      ACT_SET_MODE: begin
        seq_phase = '0;
        seq_start = '0;
        if (code == {1'b0, MODE_OFF}) begin
          stop_pattern();
          report = 1'b1;
        end else if (code <= CODE_MAX) begin
          seq_mode = code[MODE_W-1:0];
          report   = 1'b1;
        end
      end
      ACT_STOP: begin
        stop_pattern();
        report = 1'b1;
      end
      ACT_LINK_UP: begin
        seq_link = 1'b1;
        seq_led  = 1'b0;
      end
      ACT_LINK_DOWN: begin
        seq_link = 1'b0;
        stop_pattern();
      end
      ACT_UNKNOWN: report = 1'b1;
      default: ;
    endcase
    report            = report && seq_link;
    res.motor_lines   = seq_lines;
    res.led_on        = seq_led;
    res.status_valid  = report;
    res.status_mode   = report ? seq_mode : MODE_OFF;
    res.status_active = report && (seq_phase != '0);
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Drive one item, wait for its transfer, then queue what it should produce
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
                           input logic [CODE_W-1:0] code, input logic known,
                           input result_t typed);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < 34) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    now_ms     <= now;
    mode_code  <= code;
    do @(posedge clk); while (item_stall);
    step_sequencer(act, now, code, predicted);
    due_results.push_back(known ? typed : predicted);
  endtask

  // Hold off the item side until every queued result has come back
  task automatic settle();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight intervals: zeros, ones, or random values
  task automatic program_intervals(input int setting);
    logic [CFG_W-1:0] val;
    for (int i = 0; i < CFG_COUNT; i++) begin
      case (setting)
        1:       val = '0;
        2:       val = '1;
        default: val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                    : CFG_W'($urandom_range(0, 700));
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      seq_ivl[i] = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly ticks on a running clock, with pattern commands mixed in
  task automatic run_random(input bit with_calm, input bit near_wrap);
    int unsigned          n;
    int unsigned          span;
    int unsigned          pick;
    int unsigned          aim;
    bit                   paused;
    logic [ACTION_W-1:0]  act;
    logic [TIME_W-1:0]    now;
    logic [CODE_W-1:0]    code;
    logic [CFG_W-1:0]     ivl;
    span = 0;
    for (int i = 0; i < CFG_COUNT; i++) begin
      if (seq_ivl[i] > span) span = seq_ivl[i];
    end
    span   = span / 2 + 2;
    paused = 1'b0;
    n      = 0;
    // start close to the top of the time range so it wraps early
    if (near_wrap) clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 50 * span);
    while (n < RANDOM_PER_SETTING) begin
      if (n == RANDOM_PER_SETTING / 2 && !paused) begin
        settle();
        paused = 1'b1;
      end
      calm = with_calm && n >= 60 && n < 220;
      pick = $urandom_range(0, 99);
      now  = $urandom;
      code = CODE_W'($urandom);
      if (pick < 62) begin
        act = ACT_TICK;
        aim = $urandom_range(0, 99);
        if (aim < 12) begin
          // land on the phase boundary or one past it
          case (seq_mode)
            MODE_HEART: ivl = seq_ivl[seq_phase];
            MODE_FAST:  ivl = seq_phase[0] ? seq_ivl[REG_FAST_ON] : seq_ivl[REG_FAST_OFF];
            MODE_SLOW:  ivl = seq_phase[0] ? seq_ivl[REG_SLOW_ON] : seq_ivl[REG_SLOW_OFF];
            default:    ivl = '0;
          endcase
          now = seq_start + TIME_W'(ivl) + $urandom_range(0, 1);
        end else if (aim >= 16) begin
          now = clk_ms + $urandom_range(0, span);
        end
        clk_ms = now;
      end else if (pick < 74) begin
        act  = ACT_SET_MODE;
        code = $urandom_range(0, 1) ? CODE_W'($urandom_range(MODE_HEART, MODE_SLOW))
                                    : CODE_W'($urandom_range(MODE_WEAK, MODE_SLOW));
      end else if (pick < 78) begin
        act  = ACT_SET_MODE;
        code = {1'b0, MODE_OFF};
      end else if (pick < 82) begin
        act  = ACT_SET_MODE;
        code = CODE_W'($urandom_range(CODE_FIRST_BAD, CODE_TOP));
      end else if (pick < 86) begin
        act = ACT_STOP;
      end else if (pick < 91) begin
        act = ACT_LINK_UP;
      end else if (pick < 94) begin
        act = ACT_LINK_DOWN;
      end else if (pick < 98) begin
        act = ACT_UNKNOWN;
      end else begin
        act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
      end
      send_item(act, now, code, 1'b0, QUIET);
      if (act != ACT_SPARE_A && act != ACT_SPARE_B) n++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("motor_lines", 8'(want.motor_lines), 8'(motor_lines));
        check_field("led_on", 8'(want.led_on), 8'(led_on));
        check_field("status_valid", 8'(want.status_valid), 8'(status_valid));
        check_field("status_mode", 8'(want.status_mode), 8'(status_mode));
        check_field("status_active", 8'(want.status_active), 8'(status_active));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    action     = ACT_TICK;
    now_ms     = '0;
    mode_code  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_HEART_WAIT;
    cfg_data   = '0;
    calm       = 1'b0;
    mismatches = 0;
    clk_ms     = '0;
    seq_link   = 1'b0;
    seq_led    = 1'b0;
    stop_pattern();
    for (int i = 0; i < CFG_COUNT; i++) seq_ivl[i] = CFG_RESET[i];

    // Opening table: results typed in where they are obvious, else predicted
    opening_plan = '{
      '{ACT_TICK,      32'd0,        4'd0,               1'b1, QUIET},
      '{ACT_UNKNOWN,   32'd0,        4'd0,               1'b1, QUIET},
      '{ACT_SPARE_A,   32'd0,        4'd0,               1'b1, QUIET},
      '{ACT_SPARE_B,   32'hFFFFFFFF, CODE_TOP,           1'b1, QUIET},
      '{ACT_LINK_UP,   32'd0,        4'd0,               1'b1, QUIET},
      '{ACT_UNKNOWN,   32'd0,        4'd0,               1'b1,
        '{LINES_OFF, 1'b0, 1'b1, MODE_OFF, 1'b0}},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_STRONG}, 1'b1,
        '{LINES_OFF, 1'b0, 1'b1, MODE_STRONG, 1'b0}},
      '{ACT_TICK,      32'hFFFFFFFF, 4'd0,               1'b1,
        '{LINES_ALL, 1'b1, 1'b0, MODE_OFF, 1'b0}},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_WEAK},  1'b1,
        '{LINES_ALL, 1'b1, 1'b1, MODE_WEAK, 1'b0}},
      '{ACT_TICK,      32'd5,        4'd0,               1'b1,
        '{LINES_WEAK, 1'b1, 1'b0, MODE_OFF, 1'b0}},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_MED_WEAK}, 1'b0, QUIET},
      '{ACT_TICK,      32'd6,        4'd0,               1'b0, QUIET},
      // rejected mode code: old mode kept, no status
      '{ACT_SET_MODE,  32'd0,        CODE_FIRST_BAD,     1'b1,
        '{LINES_MED, 1'b1, 1'b0, MODE_OFF, 1'b0}},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_HEART}, 1'b0, QUIET},
      // heartbeat: equal to the wait does not advance, one past it does
      '{ACT_TICK,      32'd1500,     4'd0,               1'b0, QUIET},
      '{ACT_TICK,      32'd1501,     4'd0,               1'b0, QUIET},
      '{ACT_UNKNOWN,   32'd0,        4'd0,               1'b0, QUIET},
      '{ACT_TICK,      32'd1702,     4'd0,               1'b0, QUIET},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_FAST},  1'b0, QUIET},
      '{ACT_TICK,      32'd151,      4'd0,               1'b0, QUIET},
      '{ACT_TICK,      32'd252,      4'd0,               1'b0, QUIET},
      // mode code zero behaves as stop
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_OFF},   1'b1,
        '{LINES_OFF, 1'b0, 1'b1, MODE_OFF, 1'b0}},
      '{ACT_SET_MODE,  32'd0,        {1'b0, MODE_SLOW},  1'b0, QUIET},
      '{ACT_TICK,      32'd301,      4'd0,               1'b0, QUIET},
      '{ACT_STOP,      32'd0,        4'd0,               1'b1,
        '{LINES_OFF, 1'b0, 1'b1, MODE_OFF, 1'b0}},
      '{ACT_LINK_DOWN, 32'd0,        4'd0,               1'b1, QUIET}
    };

    // Hold reset, then release
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      send_item(opening_plan[r].act, opening_plan[r].now, opening_plan[r].code,
                opening_plan[r].known, opening_plan[r].res);
    end
    clk_ms = 32'd301;

    // Reset intervals first, then zeros, ones and random values
    for (int setting = 0; setting < 4; setting++) begin
      if (setting != 0) begin
        settle();
        program_intervals(setting);
      end
      run_random(setting == 1, setting != 0);
    end
    settle();

    if (mismatches == 0 && due_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== haptic_pattern_sequencer.f =====
src/hps_pkg.sv
src/hps_cfg_regs.sv
src/hps_in_reg.sv
src/hps_core.sv
src/hps_out_reg.sv
src/haptic_pattern_sequencer.sv
src/hps_checker.sv
tb/sv/tb_top.sv
